FILE: rtl/core/hlrt_pkg.sv
// Shared types and constants for the hashed LRU resource table.
package hlrt_pkg;

  // Table geometry; the port widths are sized for these values.
  localparam int unsigned ENTRY_COUNT = 2048;
  localparam int unsigned SLOT_COUNT  = 512;

  // Bit position where the resource type starts inside the high key word.
  localparam int unsigned TYPE_LSB = 32;
  localparam int unsigned TYPE_W = 32;

  // Operation class decided by the front end for each transaction.
  typedef enum logic [1:0] {
    OP_FIND,
    OP_INSERT,
    OP_UPDATE,
    OP_NOP
  } op_t;

  // One queued command travelling from the front end to the back end.
  typedef struct packed {
    op_t         op;
    logic [63:0] key_low;
    logic [63:0] key_high;
    logic [10:0] target_entry;
    logic [63:0] new_payload;
  } item_t;

  // Queue head as seen by the back end.
  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

endpackage

FILE: rtl/core/hlrt_front.sv
// Front end: accepts input transactions, classifies them and queues them.
module hlrt_front import hlrt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic        add_if_missing,
  input  logic [63:0] key_low,
  input  logic [63:0] key_high,
  input  logic [10:0] target_entry,
  input  logic [63:0] new_payload,
  input  logic        hold,
  input  logic        q_pop,
  output queue_head_t q_head
);

  item_t       ent [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;
  logic        in_range;
  item_t       new_item;

  // Classify the incoming transaction.
  assign in_range = 32'(target_entry) < ENTRY_COUNT;

  always_comb begin
    new_item.key_low      = key_low;
    new_item.key_high     = key_high;
    new_item.target_entry = target_entry;
    new_item.new_payload  = new_payload;
    if (cmd) begin
      new_item.op = in_range ? OP_UPDATE : OP_NOP;
    end else begin
      new_item.op = add_if_missing ? OP_INSERT : OP_FIND;
    end
  end

  assign in_ready = (count != 2'd2) && !hold;
  assign push = in_valid && in_ready;

  // Two-entry queue toward the back end.
  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= new_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

  assign q_head.valid = count != 2'd0;
  assign q_head.item  = ent[rd_ptr];

endmodule

FILE: rtl/core/hlrt_back.sv
// Back end: chain walk, insertion, recency list upkeep and result register.
module hlrt_back import hlrt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  queue_head_t q_head,
  output logic        q_pop,
  output logic        clearing,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [10:0] entry_id,
  output logic        hit,
  output logic        inserted,
  output logic        full_res,
  output logic [31:0] resource_type,
  output logic [63:0] payload,
  output logic [63:0] hits_total,
  output logic [63:0] misses_total
);

  localparam int unsigned IW = $clog2(ENTRY_COUNT);
  localparam int unsigned SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CLR_LEN = (ENTRY_COUNT > SLOT_COUNT) ? ENTRY_COUNT : SLOT_COUNT;
  localparam int unsigned CW = $clog2(CLR_LEN);
  localparam logic [31:0] SLOT_MASK = 32'(SLOT_COUNT - 1);

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_WALK, S_CMP, S_POP, S_PF1, S_PF2, S_OUT
  } state_t;

  state_t state;
  item_t  it;
  logic [SW-1:0] it_slot;
  logic [SW-1:0] q_slot;
  logic [CW-1:0] clr;
  logic [IW-1:0] cur;
  logic [IW-1:0] head;
  logic [IW-1:0] free_head;
  logic [IW-1:0] rn0;
  logic [IW-1:0] cand;
  logic [IW-1:0] rd_idx;
  logic [63:0]   hit_counter;
  logic [63:0]   miss_counter;
  logic          match;
  logic          out_free;

  // Result being assembled for the current transaction.
  logic [IW-1:0] res_id;
  logic          res_hit;
  logic          res_ins;
  logic          res_full;
  logic [31:0]   res_type;
  logic [63:0]   res_payload;

  // Memories and their ports.
  logic [IW-1:0] sh_mem [SLOT_COUNT];
  logic [IW-1:0] cn_mem [ENTRY_COUNT];
  logic [IW-1:0] rp_mem [ENTRY_COUNT];
  logic [IW-1:0] rn_mem [ENTRY_COUNT];
  logic [63:0]   klo_mem [ENTRY_COUNT];
  logic [63:0]   khi_mem [ENTRY_COUNT];
  logic [31:0]   ty_mem [ENTRY_COUNT];
  logic [63:0]   pl_mem [ENTRY_COUNT];

  logic [IW-1:0] sh_rd, cn_rd, rp_rd, rn_rd;
  logic [63:0]   klo_rd, khi_rd, pl_rd;
  logic [31:0]   ty_rd;

  logic          sh_we, cn_we, rp_we, rn_we, key_we, tp_we;
  logic [SW-1:0] sh_wa;
  logic [IW-1:0] sh_wd, cn_wa, cn_wd, rp_wa, rp_wd, rn_wa, rn_wd, key_wa, tp_wa;
  logic [63:0]   klo_wd, khi_wd, pl_wd;
  logic [31:0]   ty_wd;

  assign clearing = state == S_CLR;
  assign q_pop    = (state == S_IDLE) && q_head.valid;
  assign q_slot   = SW'(q_head.item.key_low[31:0] & SLOT_MASK);
  assign match    = (klo_rd == it.key_low) && (khi_rd == it.key_high);
  assign cand     = (state == S_WALK) ? sh_rd : cn_rd;
  assign rd_idx   = (cand != '0) ? cand : free_head;
  assign out_free = !out_valid || out_ready;

  // Write port selection for every memory.
  always_comb begin
    sh_we = 1'b0; sh_wa = SW'(clr); sh_wd = '0;
    cn_we = 1'b0; cn_wa = IW'(clr); cn_wd = '0;
    rp_we = 1'b0; rp_wa = IW'(clr); rp_wd = '0;
    rn_we = 1'b0; rn_wa = IW'(clr); rn_wd = '0;
    key_we = 1'b0; key_wa = free_head; klo_wd = it.key_low; khi_wd = it.key_high;
    tp_we = 1'b0; tp_wa = IW'(clr); ty_wd = '0; pl_wd = '0;
    case (state)
      S_CLR: begin
        sh_we = 32'(clr) < SLOT_COUNT;
        cn_we = 32'(clr) < ENTRY_COUNT;
        cn_wd = ((32'(clr) + 32'd1) < ENTRY_COUNT) ? IW'(32'(clr) + 32'd1) : '0;
        rp_we = 32'(clr) < ENTRY_COUNT;
        rn_we = 32'(clr) < ENTRY_COUNT;
        tp_we = 32'(clr) < ENTRY_COUNT;
      end
      S_IDLE: begin
        key_we = q_head.valid && (q_head.item.op == OP_UPDATE);
        tp_we  = key_we;
        key_wa = IW'(q_head.item.target_entry);
        tp_wa  = IW'(q_head.item.target_entry);
        klo_wd = q_head.item.key_low;
        khi_wd = q_head.item.key_high;
        ty_wd  = q_head.item.key_high[TYPE_LSB +: TYPE_W];
        pl_wd  = q_head.item.new_payload;
      end
      S_CMP: begin
        // Unlink the hit entry from its place in the recency list.
        rp_we = match;
        rp_wa = rn_rd;
        rp_wd = rp_rd;
        rn_we = match && (rp_rd != '0);
        rn_wa = rp_rd;
        rn_wd = rn_rd;
      end
      S_POP: begin
        sh_we = 1'b1; sh_wa = it_slot; sh_wd = free_head;
        cn_we = 1'b1; cn_wa = free_head; cn_wd = head;
        key_we = 1'b1;
      end
      S_PF1: begin
        rn_we = 1'b1; rn_wa = cur; rn_wd = rn0;
        rp_we = 1'b1; rp_wa = cur; rp_wd = '0;
      end
      S_PF2: begin
        rp_we = 1'b1; rp_wa = rn0; rp_wd = cur;
      end
      default: begin
      end
    endcase
  end

  // Memory arrays with registered reads.
  always_ff @(posedge clk) begin
    if (sh_we) sh_mem[sh_wa] <= sh_wd;
    if (cn_we) cn_mem[cn_wa] <= cn_wd;
    if (rp_we) rp_mem[rp_wa] <= rp_wd;
    if (rn_we) rn_mem[rn_wa] <= rn_wd;
    if (key_we) begin
      klo_mem[key_wa] <= klo_wd;
      khi_mem[key_wa] <= khi_wd;
    end
    if (tp_we) begin
      ty_mem[tp_wa] <= ty_wd;
      pl_mem[tp_wa] <= pl_wd;
    end
    sh_rd  <= sh_mem[q_slot];
    cn_rd  <= cn_mem[rd_idx];
    rp_rd  <= rp_mem[rd_idx];
    rn_rd  <= rn_mem[rd_idx];
    klo_rd <= klo_mem[rd_idx];
    khi_rd <= khi_mem[rd_idx];
    ty_rd  <= ty_mem[rd_idx];
    pl_rd  <= pl_mem[rd_idx];
  end

  // Sequencer: state, list heads, counters and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLR;
      clr          <= '0;
      free_head    <= IW'(1);
      rn0          <= '0;
      hit_counter  <= '0;
      miss_counter <= '0;
      out_valid    <= 1'b0;
    end else begin
      // The output register empties on a handshake unless a new result loads.
      if (out_valid && out_ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          clr <= clr + CW'(1);
          if (clr == CW'(CLR_LEN - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_head.valid) begin
            it       <= q_head.item;
            it_slot  <= q_slot;
            res_hit  <= 1'b0;
            res_ins  <= 1'b0;
            res_full <= 1'b0;
            if (q_head.item.op == OP_UPDATE) begin
              res_id      <= IW'(q_head.item.target_entry);
              res_type    <= q_head.item.key_high[TYPE_LSB +: TYPE_W];
              res_payload <= q_head.item.new_payload;
              state       <= S_OUT;
            end else begin
              res_id      <= '0;
              res_type    <= '0;
              res_payload <= '0;
              state       <= (q_head.item.op == OP_NOP) ? S_OUT : S_WALK;
            end
          end
        end
        S_WALK, S_CMP: begin
          if (state == S_WALK) begin
            head <= sh_rd;
          end
          if ((state == S_CMP) && match) begin
            res_id      <= cur;
            res_hit     <= 1'b1;
            res_type    <= ty_rd;
            res_payload <= pl_rd;
            hit_counter <= hit_counter + 64'd1;
            if (rp_rd == '0) begin
              rn0 <= rn_rd;
            end
            state <= S_PF1;
          end else if (cand != '0) begin
            cur   <= cand;
            state <= S_CMP;
          end else if ((it.op == OP_INSERT) && (free_head != '0)) begin
            cur   <= free_head;
            state <= S_POP;
          end else begin
            res_full <= it.op == OP_INSERT;
            state    <= S_OUT;
          end
        end
        S_POP: begin
          free_head    <= cn_rd;
          res_id       <= cur;
          res_ins      <= 1'b1;
          res_type     <= ty_rd;
          res_payload  <= pl_rd;
          miss_counter <= miss_counter + 64'd1;
          state        <= S_PF1;
        end
        S_PF1: begin
          state <= S_PF2;
        end
        S_PF2: begin
          rn0   <= cur;
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            entry_id      <= 11'(res_id);
            hit           <= res_hit;
            inserted      <= res_ins;
            full_res      <= res_full;
            resource_type <= res_type;
            payload       <= res_payload;
            hits_total    <= hit_counter;
            misses_total  <= miss_counter;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_result_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !out_valid) else $error("result during clearing pass");
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $countones({hit, inserted, full_res}) <= 1)
    else $error("more than one outcome flag set");
  a_full_gives_none: assert property (@(posedge clk) disable iff (rst)
    (out_valid && full_res) |-> (entry_id == '0 && resource_type == '0))
    else $error("full result carries an entry");
  a_hit_count_step: assert property (@(posedge clk) disable iff (rst)
    !clearing |=> (hit_counter == $past(hit_counter)) ||
                  (hit_counter == $past(hit_counter) + 64'd1))
    else $error("hit counter jumped");
  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (state != S_IDLE) && (state != S_CLR))
    else $error("queue popped without starting work");
`endif

endmodule

FILE: rtl/core/hashed_lru_resource_table.sv
// Top level of the hashed LRU resource table: front end, queue and back end.
// Update: the item is written to the key, type and payload memories in S_IDLE and the
// result register loads from S_OUT. Find: the chain is walked through S_WALK and S_CMP;
// a hit adds S_PF1 and S_PF2 and an insert S_POP, S_PF1 and S_PF2 for the recency list
// writes. Reset is synchronous; a clearing pass of max(ENTRY_COUNT, SLOT_COUNT) addresses
// then initializes the chain, type and payload memories before in_ready rises.
module hashed_lru_resource_table import hlrt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic        add_if_missing,
  input  logic [63:0] key_low,
  input  logic [63:0] key_high,
  input  logic [10:0] target_entry,
  input  logic [63:0] new_payload,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [10:0] entry_id,
  output logic        hit,
  output logic        inserted,
  output logic        full_res,
  output logic [31:0] resource_type,
  output logic [63:0] payload,
  output logic [63:0] hits_total,
  output logic [63:0] misses_total
);

  queue_head_t q_head;
  logic        q_pop;
  logic        clearing;

  // Front end with command queue.
  hlrt_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .cmd            (cmd),
    .add_if_missing (add_if_missing),
    .key_low        (key_low),
    .key_high       (key_high),
    .target_entry   (target_entry),
    .new_payload    (new_payload),
    .hold           (clearing),
    .q_pop          (q_pop),
    .q_head         (q_head)
  );

  // Back end with the table memories.
  hlrt_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .clearing      (clearing),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .entry_id      (entry_id),
    .hit           (hit),
    .inserted      (inserted),
    .full_res      (full_res),
    .resource_type (resource_type),
    .payload       (payload),
    .hits_total    (hits_total),
    .misses_total  (misses_total)
  );

endmodule
